// ----- hdl/osws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package osws_pkg;

  // field widths
  localparam int DIM_W  = 13;
  localparam int POS_W  = 14;
  localparam int FRAC_W = 12;
  localparam int NUM_W  = DIM_W + FRAC_W;
  localparam int WORD_W = 32;
  localparam int ADDR_W = 3;

  // fixed-point constants
  localparam logic [NUM_W-1:0] ONE_STEP = NUM_W'(1 << FRAC_W);
  localparam int LUMA_INT_SH  = 15;
  localparam int FRAC_X_SH    = 3;
  localparam int FRAC_Y_SH    = 20;
  localparam int VERT_LUMA_SH = 16;

  // defaults
  localparam int MAX_RATIO_DEF = 7;
  localparam logic [DIM_W-1:0] DISP_W_RST = DIM_W'(1920);
  localparam logic [DIM_W-1:0] DISP_H_RST = DIM_W'(1080);

  // register index (address bit 2)
  localparam logic REG_DISP_W = 1'b0;
  localparam logic REG_DISP_H = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RATIO = 2'd2
  } status_t;

  // one clipped axis
  typedef struct packed {
    logic [DIM_W-1:0] pos;
    logic [DIM_W-1:0] len;
    logic             empty;
  } clip_t;

  // packed scale words and checks
  typedef struct packed {
    logic [WORD_W-1:0] luma;
    logic [WORD_W-1:0] chroma;
    logic [WORD_W-1:0] vint;
    logic              changed;
    logic              ratio_err;
  } scale_t;

endpackage

`default_nettype wire

// ----- hdl/overlay_scale_window_setup.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  beat
// in_       input      in_valid / in_ready        source size, requested window
// out_      output     out_valid / out_ready      window, scale words, status
// cfg       input      psel, penable, pwrite      display width / height
//
// a beat skips the divide step when the window is empty or the sizes match, else
// the two 25-bit bit-serial dividers (x and y in parallel) compute the scale steps
// a new beat is taken while the previous result still waits in the output register
// rst_n is synchronous; it clears control and the stored scale words and
// restores the default display size
// out_ready low only holds the finished beat in its last state

module overlay_scale_window_setup
  import osws_pkg::*;
#(
  parameter int MAX_RATIO = MAX_RATIO_DEF
)(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic        [DIM_W-1:0]  in_src_width,
  input  wire logic        [DIM_W-1:0]  in_src_height,
  input  wire logic signed [POS_W-1:0]  in_dst_x,
  input  wire logic signed [POS_W-1:0]  in_dst_y,
  input  wire logic signed [POS_W-1:0]  in_dst_w,
  input  wire logic signed [POS_W-1:0]  in_dst_h,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic             [WORD_W-1:0] out_win_pos_word,
  output logic             [WORD_W-1:0] out_win_size_word,
  output logic             [WORD_W-1:0] out_luma_scale_word,
  output logic             [WORD_W-1:0] out_chroma_scale_word,
  output logic             [WORD_W-1:0] out_vert_int_word,
  output logic                          out_scale_changed,
  output logic             [1:0]        out_status,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic        [ADDR_W-1:0] paddr,
  input  wire logic        [WORD_W-1:0] pwdata,
  output logic             [WORD_W-1:0] prdata,
  output logic                          pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLIP  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] disp_w_r, disp_w_nxt;
  logic [DIM_W-1:0] disp_h_r, disp_h_nxt;

  logic        [DIM_W-1:0] src_w_r, src_h_r;
  logic signed [POS_W-1:0] dst_x_r, dst_y_r, dst_w_r, dst_h_r;
  logic                    take_in;

  clip_t xclip, yclip;
  clip_t xclip_r, yclip_r, xclip_nxt, yclip_nxt;

  logic [NUM_W-1:0] xf_r, xf_nxt, yf_r, yf_nxt;
  logic             div_start;
  logic [NUM_W-1:0] x_num, y_num, x_quo, y_quo;
  logic             x_done, y_done;
  logic             sizes_equal;

  scale_t scale;
  logic   load_out;
  logic   commit;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_pos_r, out_pos_nxt;
  logic [WORD_W-1:0] out_size_r, out_size_nxt;
  logic [WORD_W-1:0] out_luma_r, out_luma_nxt;
  logic [WORD_W-1:0] out_chroma_r, out_chroma_nxt;
  logic [WORD_W-1:0] out_vint_r, out_vint_nxt;
  logic              out_changed_r, out_changed_nxt;
  status_t           out_status_r, out_status_nxt;

  // configuration registers
  always_comb begin
    disp_w_nxt = disp_w_r;
    disp_h_nxt = disp_h_r;
    if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DISP_W: disp_w_nxt = pwdata[DIM_W-1:0];
        REG_DISP_H: disp_h_nxt = pwdata[DIM_W-1:0];
        default:    disp_w_nxt = disp_w_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_DISP_H) ? WORD_W'(disp_h_r) : WORD_W'(disp_w_r);
  assign pready = 1'b1;

  // input capture
  assign in_ready = (state_r == ST_IDLE);
  assign take_in  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (take_in) begin
      src_w_r <= in_src_width;
      src_h_r <= in_src_height;
      dst_x_r <= in_dst_x;
      dst_y_r <= in_dst_y;
      dst_w_r <= in_dst_w;
      dst_h_r <= in_dst_h;
    end
  end

  // window clipping per axis
  osws_clip u_clip_x (
    .pos_i   (dst_x_r),
    .len_i   (dst_w_r),
    .limit_i (disp_w_r),
    .clip_o  (xclip)
  );

  osws_clip u_clip_y (
    .pos_i   (dst_y_r),
    .len_i   (dst_h_r),
    .limit_i (disp_h_r),
    .clip_o  (yclip)
  );

  assign xclip_nxt = (state_r == ST_CLIP) ? xclip : xclip_r;
  assign yclip_nxt = (state_r == ST_CLIP) ? yclip : yclip_r;

  always_ff @(posedge clk) begin
    xclip_r <= xclip_nxt;
    yclip_r <= yclip_nxt;
  end

  // scale steps: ((src - 1) << 12) / dst
  assign sizes_equal = (src_w_r == xclip_r.len) && (src_h_r == yclip_r.len);
  assign x_num = {((src_w_r == '0) ? src_w_r : (src_w_r - DIM_W'(1))), FRAC_W'(0)};
  assign y_num = {((src_h_r == '0) ? src_h_r : (src_h_r - DIM_W'(1))), FRAC_W'(0)};
  assign div_start = (state_r == ST_CHECK) && !xclip_r.empty && !yclip_r.empty &&
                     !sizes_equal;

  osws_div #(.NUM_BITS(NUM_W), .DEN_BITS(DIM_W)) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (x_num),
    .den_i   (xclip_r.len),
    .done_o  (x_done),
    .quo_o   (x_quo)
  );

  osws_div #(.NUM_BITS(NUM_W), .DEN_BITS(DIM_W)) u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (y_num),
    .den_i   (yclip_r.len),
    .done_o  (y_done),
    .quo_o   (y_quo)
  );

  // packing, ratio check, change detect
  osws_pack #(.MAX_RATIO(MAX_RATIO)) u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .xf_i     (xf_r),
    .yf_i     (yf_r),
    .commit_i (commit),
    .scale_o  (scale)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    xf_nxt    = xf_r;
    yf_nxt    = yf_r;
    case (state_r)
      ST_IDLE: begin
        if (take_in) state_nxt = ST_CLIP;
      end
      ST_CLIP: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (xclip_r.empty || yclip_r.empty) begin
          state_nxt = ST_DONE;
        end else if (sizes_equal) begin
          xf_nxt    = ONE_STEP;
          yf_nxt    = ONE_STEP;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (x_done) begin
          xf_nxt    = x_quo;
          yf_nxt    = y_quo;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result register
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign commit   = load_out && !xclip_r.empty && !yclip_r.empty && !scale.ratio_err;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_pos_nxt     = out_pos_r;
    out_size_nxt    = out_size_r;
    out_luma_nxt    = out_luma_r;
    out_chroma_nxt  = out_chroma_r;
    out_vint_nxt    = out_vint_r;
    out_changed_nxt = out_changed_r;
    out_status_nxt  = out_status_r;
    if (load_out) begin
      out_valid_nxt   = 1'b1;
      out_pos_nxt     = '0;
      out_size_nxt    = '0;
      out_luma_nxt    = '0;
      out_chroma_nxt  = '0;
      out_vint_nxt    = '0;
      out_changed_nxt = 1'b0;
      if (xclip_r.empty || yclip_r.empty) begin
        out_status_nxt = STAT_EMPTY;
      end else begin
        out_pos_nxt  = (WORD_W'(yclip_r.pos) << 16) | WORD_W'(xclip_r.pos);
        out_size_nxt = (WORD_W'(yclip_r.len) << 16) | WORD_W'(xclip_r.len);
        if (scale.ratio_err) begin
          out_status_nxt = STAT_RATIO;
        end else begin
          out_status_nxt  = STAT_OK;
          out_luma_nxt    = scale.luma;
          out_chroma_nxt  = scale.chroma;
          out_vint_nxt    = scale.vint;
          out_changed_nxt = scale.changed;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      disp_w_r    <= DISP_W_RST;
      disp_h_r    <= DISP_H_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      disp_w_r    <= disp_w_nxt;
      disp_h_r    <= disp_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xf_r          <= xf_nxt;
    yf_r          <= yf_nxt;
    out_pos_r     <= out_pos_nxt;
    out_size_r    <= out_size_nxt;
    out_luma_r    <= out_luma_nxt;
    out_chroma_r  <= out_chroma_nxt;
    out_vint_r    <= out_vint_nxt;
    out_changed_r <= out_changed_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_win_pos_word      = out_pos_r;
  assign out_win_size_word     = out_size_r;
  assign out_luma_scale_word   = out_luma_r;
  assign out_chroma_scale_word = out_chroma_r;
  assign out_vert_int_word     = out_vint_r;
  assign out_scale_changed     = out_changed_r;
  assign out_status            = out_status_r;

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    x_done |-> (y_done && (state_r == ST_DIV)))
    else $error("dividers out of step");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_EMPTY)) |->
      ((out_pos_r == '0) && (out_size_r == '0) && (out_luma_r == '0)))
    else $error("empty window beat carries data");

  a_ratio_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_RATIO)) |->
      (!out_changed_r && (out_luma_r == '0) && (out_vint_r == '0)))
    else $error("ratio error beat carries scale words");

endmodule

`default_nettype wire

// ----- hdl/osws_clip.sv -----
`timescale 1ns / 1ps
`default_nettype none

module osws_clip
  import osws_pkg::*;
(
  input  wire logic signed [POS_W-1:0] pos_i,
  input  wire logic signed [POS_W-1:0] len_i,
  input  wire logic        [DIM_W-1:0] limit_i,
  output clip_t                        clip_o
);

  logic        [DIM_W-1:0] pos_c;
  logic signed [POS_W:0]   pos_s;
  logic signed [POS_W:0]   lim_s;
  logic signed [POS_W:0]   sum_s;
  logic signed [POS_W:0]   len_s;

  // negative edge clamps to zero
  assign pos_c = pos_i[POS_W-1] ? '0 : pos_i[DIM_W-1:0];
  assign pos_s = $signed({2'b00, pos_c});
  assign lim_s = $signed({2'b00, limit_i});
  assign sum_s = pos_s + $signed({len_i[POS_W-1], len_i});

  // cut length back to the display edge
  assign len_s = (sum_s > lim_s) ? (lim_s - pos_s) : $signed({len_i[POS_W-1], len_i});

  assign clip_o.pos   = pos_c;
  assign clip_o.len   = len_s[DIM_W-1:0];
  assign clip_o.empty = len_s[POS_W] || (len_s == '0);

endmodule

`default_nettype wire

// ----- hdl/osws_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module osws_div
  import osws_pkg::*;
#(
  parameter int NUM_BITS = NUM_W,
  parameter int DEN_BITS = DIM_W
)(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start_i,
  input  wire logic [NUM_BITS-1:0] num_i,
  input  wire logic [DEN_BITS-1:0] den_i,
  output logic                     done_o,
  output logic [NUM_BITS-1:0]      quo_o
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DEN_BITS-1:0] rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r, den_nxt;
  logic [NUM_BITS-1:0] quo_r, quo_nxt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // one quotient bit per cycle, dividend shifts out msb first
  assign trial = {rem_r, quo_r[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_BITS);
      rem_nxt  = '0;
      den_nxt  = den_i;
      quo_nxt  = num_i;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo_nxt = {quo_r[NUM_BITS-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |=> busy_r)
    else $error("divider did not start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");

endmodule

`default_nettype wire

// ----- hdl/osws_pack.sv -----
`timescale 1ns / 1ps
`default_nettype none

module osws_pack
  import osws_pkg::*;
#(
  parameter int MAX_RATIO = MAX_RATIO_DEF
)(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [NUM_W-1:0] xf_i,
  input  wire logic [NUM_W-1:0] yf_i,
  input  wire logic             commit_i,
  output scale_t                scale_o
);

  localparam logic [DIM_W-1:0] MAX_EXT = DIM_W'(MAX_RATIO);

  logic [WORD_W-1:0] prev_luma_r, prev_luma_nxt;
  logic [WORD_W-1:0] prev_chroma_r, prev_chroma_nxt;
  logic [WORD_W-1:0] prev_vint_r, prev_vint_nxt;

  logic [DIM_W-1:0]  xi, yi;
  logic [DIM_W-2:0]  xic, yic;
  logic [FRAC_W-1:0] xfr, yfr, xfrc, yfrc;
  logic [WORD_W-1:0] luma, chroma, vint;

  // chroma step is half, luma step forced even
  assign xi   = xf_i[NUM_W-1:FRAC_W];
  assign yi   = yf_i[NUM_W-1:FRAC_W];
  assign xic  = xf_i[NUM_W-1:FRAC_W+1];
  assign yic  = yf_i[NUM_W-1:FRAC_W+1];
  assign xfr  = {xf_i[FRAC_W-1:1], 1'b0};
  assign yfr  = {yf_i[FRAC_W-1:1], 1'b0};
  assign xfrc = xf_i[FRAC_W:1];
  assign yfrc = yf_i[FRAC_W:1];

  // word packing
  assign luma   = (WORD_W'(xi) << LUMA_INT_SH) | (WORD_W'(xfr) << FRAC_X_SH) |
                  (WORD_W'(yfr) << FRAC_Y_SH);
  assign chroma = (WORD_W'(xic) << LUMA_INT_SH) | (WORD_W'(xfrc) << FRAC_X_SH) |
                  (WORD_W'(yfrc) << FRAC_Y_SH);
  assign vint   = (WORD_W'(yi) << VERT_LUMA_SH) | WORD_W'(yic);

  assign scale_o.luma      = luma;
  assign scale_o.chroma    = chroma;
  assign scale_o.vint      = vint;
  assign scale_o.ratio_err = (xi > MAX_EXT) || ({1'b0, xic} > MAX_EXT);
  assign scale_o.changed   = (luma != prev_luma_r) || (chroma != prev_chroma_r) ||
                             (vint != prev_vint_r);

  // stored previous words
  assign prev_luma_nxt   = commit_i ? luma : prev_luma_r;
  assign prev_chroma_nxt = commit_i ? chroma : prev_chroma_r;
  assign prev_vint_nxt   = commit_i ? vint : prev_vint_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_luma_r   <= '0;
      prev_chroma_r <= '0;
      prev_vint_r   <= '0;
    end else begin
      prev_luma_r   <= prev_luma_nxt;
      prev_chroma_r <= prev_chroma_nxt;
      prev_vint_r   <= prev_vint_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- bench/overlay_scale_window_setup_tb.sv -----
`timescale 1ns / 1ps

module overlay_scale_window_setup_tb;
  import osws_pkg::*;

  localparam int RATIO_LIMIT = MAX_RATIO_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;

  // one set-up request as it enters the block
  typedef struct {
    logic        [DIM_W-1:0] src_width;
    logic        [DIM_W-1:0] src_height;
    logic signed [POS_W-1:0] dst_x;
    logic signed [POS_W-1:0] dst_y;
    logic signed [POS_W-1:0] dst_w;
    logic signed [POS_W-1:0] dst_h;
  } setup_req_t;

  // one window / scale result
  typedef struct {
    logic [WORD_W-1:0] win_pos;
    logic [WORD_W-1:0] win_size;
    logic [WORD_W-1:0] luma;
    logic [WORD_W-1:0] chroma;
    logic [WORD_W-1:0] vint;
    logic              changed;
    status_t           status;
  } window_result_t;

  // window clipping and scale step prediction, with the expected results in order
  class window_scoreboard;
    logic [DIM_W-1:0]  disp_w;
    logic [DIM_W-1:0]  disp_h;
    logic [WORD_W-1:0] prev_luma;
    logic [WORD_W-1:0] prev_chroma;
    logic [WORD_W-1:0] prev_vint;
    window_result_t    pending_q[$];
    int                mismatches;

    function new();
      disp_w = DISP_W_RST;
      disp_h = DISP_H_RST;
      prev_luma = '0;
      prev_chroma = '0;
      prev_vint = '0;
      mismatches = 0;
    endfunction

    function void set_display(logic idx, logic [DIM_W-1:0] value);
      if (idx == REG_DISP_W) begin
        disp_w = value;
      end else begin
        disp_h = value;
      end
    endfunction

    function int pending_count();
      return pending_q.size();
    endfunction

    // 12-bit fraction step, zero source size taken as numerator 0
    function int unsigned scale_step(int unsigned src, int unsigned dst);
      int unsigned num;
      num = (src > 0) ? src - 1 : 0;
      return (num << FRAC_W) / dst;
    endfunction

    function void note_request(setup_req_t r);
      window_result_t res;
      int x, y, w, h, dw, dh;
      int unsigned sw, sh, xf, yf, xfc, yfc, xi, yi, xic, yic;
      sw = r.src_width;
      sh = r.src_height;
      x = r.dst_x;
      y = r.dst_y;
      w = r.dst_w;
      h = r.dst_h;
      dw = disp_w;
      dh = disp_h;
      res.win_pos = '0;
      res.win_size = '0;
      res.luma = '0;
      res.chroma = '0;
      res.vint = '0;
      res.changed = 1'b0;
      res.status = STAT_OK;
      // clip the window to the display
      if (x < 0) x = 0;
      if (y < 0) y = 0;
      if (x + w > dw) w = dw - x;
      if (y + h > dh) h = dh - y;
      if (w <= 0 || h <= 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.win_pos = {y[15:0], x[15:0]};
        res.win_size = {h[15:0], w[15:0]};
        // exact 1.0 when both sizes match, else divide
        if (sw == unsigned'(w) && sh == unsigned'(h)) begin
          xf = 1 << FRAC_W;
          yf = 1 << FRAC_W;
        end else begin
          xf = scale_step(sw, unsigned'(w));
          yf = scale_step(sh, unsigned'(h));
        end
        // chroma is half of luma, luma forced even
        xfc = xf / 2;
        yfc = yf / 2;
        xf = xfc * 2;
        yf = yfc * 2;
        xi = xf >> FRAC_W;
        yi = yf >> FRAC_W;
        xic = xfc >> FRAC_W;
        yic = yfc >> FRAC_W;
        if (xi > RATIO_LIMIT || xic > RATIO_LIMIT) begin
          res.status = STAT_RATIO;
        end else begin
          res.luma = (xi << LUMA_INT_SH) | ((xf & 32'hFFF) << FRAC_X_SH) |
                     ((yf & 32'hFFF) << FRAC_Y_SH);
          res.chroma = (xic << LUMA_INT_SH) | ((xfc & 32'hFFF) << FRAC_X_SH) |
                       ((yfc & 32'hFFF) << FRAC_Y_SH);
          res.vint = (yi << VERT_LUMA_SH) | yic;
          res.changed = (res.luma != prev_luma) || (res.chroma != prev_chroma) ||
                        (res.vint != prev_vint);
          prev_luma = res.luma;
          prev_chroma = res.chroma;
          prev_vint = res.vint;
        end
      end
      pending_q = {pending_q, res};
    endfunction

    function void flag_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
        if (mismatches < 10) begin
          $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
        mismatches++;
      end
    endfunction

    function void check_result(window_result_t got);
      window_result_t want;
      if (pending_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("result beat with nothing expected: pos %h size %h status %0d",
                   got.win_pos, got.win_size, got.status);
        end
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        flag_field("win_pos_word", want.win_pos, got.win_pos);
        flag_field("win_size_word", want.win_size, got.win_size);
        flag_field("luma_scale_word", want.luma, got.luma);
        flag_field("chroma_scale_word", want.chroma, got.chroma);
        flag_field("vert_int_word", want.vint, got.vint);
        flag_field("scale_changed", WORD_W'(want.changed), WORD_W'(got.changed));
        flag_field("status", WORD_W'(want.status), WORD_W'(got.status));
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic        [DIM_W-1:0]  in_src_width = '0;
  logic        [DIM_W-1:0]  in_src_height = '0;
  logic signed [POS_W-1:0]  in_dst_x = '0;
  logic signed [POS_W-1:0]  in_dst_y = '0;
  logic signed [POS_W-1:0]  in_dst_w = '0;
  logic signed [POS_W-1:0]  in_dst_h = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic        [WORD_W-1:0] out_win_pos_word;
  logic        [WORD_W-1:0] out_win_size_word;
  logic        [WORD_W-1:0] out_luma_scale_word;
  logic        [WORD_W-1:0] out_chroma_scale_word;
  logic        [WORD_W-1:0] out_vert_int_word;
  logic                     out_scale_changed;
  logic        [1:0]        out_status;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic        [ADDR_W-1:0] paddr = '0;
  logic        [WORD_W-1:0] pwdata = '0;
  logic        [WORD_W-1:0] prdata;
  logic                     pready;

  window_scoreboard sb = new();
  int quiet_cycles = 0;
  int ready_run = 0;
  logic ready_level = 1'b0;

  overlay_scale_window_setup dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_src_width          (in_src_width),
    .in_src_height         (in_src_height),
    .in_dst_x              (in_dst_x),
    .in_dst_y              (in_dst_y),
    .in_dst_w              (in_dst_w),
    .in_dst_h              (in_dst_h),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_win_pos_word      (out_win_pos_word),
    .out_win_size_word     (out_win_size_word),
    .out_luma_scale_word   (out_luma_scale_word),
    .out_chroma_scale_word (out_chroma_scale_word),
    .out_vert_int_word     (out_vert_int_word),
    .out_scale_changed     (out_scale_changed),
    .out_status            (out_status),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check accepted beats, stall on a run-length pattern
  always @(posedge clk) begin : result_side
    window_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.win_pos = out_win_pos_word;
      got.win_size = out_win_size_word;
      got.luma = out_luma_scale_word;
      got.chroma = out_chroma_scale_word;
      got.vint = out_vert_int_word;
      got.changed = out_scale_changed;
      got.status = status_t'(out_status);
      sb.check_result(got);
    end
    if (ready_run == 0) begin
      if (!ready_level) begin
        ready_level = 1'b1;
        ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) :
                                                  $urandom_range(1, 10);
      end else begin
        ready_level = 1'b0;
        ready_run = $urandom_range(1, 25);
      end
    end else begin
      ready_run--;
    end
    out_ready <= ready_level;
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic setup_req_t make_setup(int sw, int sh, int x, int y, int w, int h);
    setup_req_t r;
    r.src_width = DIM_W'(sw);
    r.src_height = DIM_W'(sh);
    r.dst_x = POS_W'(x);
    r.dst_y = POS_W'(y);
    r.dst_w = POS_W'(w);
    r.dst_h = POS_W'(h);
    return r;
  endfunction

  // mostly windows inside the display with a sane ratio, plus edge hangs, over-ratio widths and noise
  function automatic setup_req_t random_setup(int dw, int dh);
    setup_req_t r;
    int pick, wcap, w, h, x, y;
    pick = $urandom_range(0, 99);
    if (dw < 1) dw = 1;
    if (dh < 1) dh = 1;
    if (pick < 12) begin
      r.src_width = DIM_W'($urandom);
      r.src_height = DIM_W'($urandom);
      r.dst_x = POS_W'($urandom);
      r.dst_y = POS_W'($urandom);
      r.dst_w = POS_W'($urandom);
      r.dst_h = POS_W'($urandom);
    end else begin
      wcap = (pick >= 90 && dw > 1023) ? 1023 : dw;
      w = $urandom_range(1, wcap);
      h = $urandom_range(1, dh);
      x = $urandom_range(0, dw - w);
      y = $urandom_range(0, dh - h);
      r.src_width = DIM_W'($urandom_range(1, (8 * w > 8191) ? 8191 : 8 * w));
      r.src_height = DIM_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 8191 :
                                              ((8 * h > 8191) ? 8191 : 8 * h)));
      if (pick < 30) begin
        // hang over an edge
        x = x - $urandom_range(0, 64);
        y = y - $urandom_range(0, 64);
        w = w + $urandom_range(0, 300);
        h = h + $urandom_range(0, 300);
        if (w > 8191) w = 8191;
        if (h > 8191) h = 8191;
      end else if (pick < 45) begin
        r.src_width = DIM_W'(w);
        r.src_height = DIM_W'(h);
      end else if (pick >= 90) begin
        r.src_width = DIM_W'($urandom_range(8 * w + 1, 8191));
      end
      r.dst_x = POS_W'(x);
      r.dst_y = POS_W'(y);
      r.dst_w = POS_W'(w);
      r.dst_h = POS_W'(h);
    end
    return r;
  endfunction

  // feed set-up beats in bursts with random gaps, sometimes draining the block
  task automatic feed_setups(input setup_req_t items[$]);
    int burst_left;
    int gap;
    bit drain;
    burst_left = $urandom_range(1, 24);
    foreach (items[i]) begin
      in_valid <= 1'b1;
      in_src_width <= items[i].src_width;
      in_src_height <= items[i].src_height;
      in_dst_x <= items[i].dst_x;
      in_dst_y <= items[i].dst_y;
      in_dst_w <= items[i].dst_w;
      in_dst_h <= items[i].dst_h;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note_request(items[i]);
      drain = ($urandom_range(0, 59) == 0);
      if (burst_left == 0 || drain || i == items.size() - 1) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
        if (drain) begin
          while (sb.pending_count() != 0) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) :
                                                   $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle_block();
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_display_reg(logic idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= WORD_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_display(idx, DIM_W'(value));
  endtask

  task automatic set_display(int dw, int dh);
    settle_block();
    write_display_reg(REG_DISP_W, dw);
    write_display_reg(REG_DISP_H, dh);
    @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    setup_req_t items[$];
    int dw, dh, count;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases at the reset display size
    items = {items, make_setup(1920, 1080, 0, 0, 1920, 1080)};
    items = {items, make_setup(1920, 1080, 0, 0, 1920, 1080)};
    items = {items, make_setup(8191, 8191, 0, 0, 100, 100)};
    items = {items, make_setup(1, 1, 0, 0, 8191, 8191)};
    items = {items, make_setup(8191, 8191, -8192, -8192, 8191, 8191)};
    items = {items, make_setup(100, 100, 8191, 8191, 10, 10)};
    items = {items, make_setup(100, 100, 1920, 0, 10, 10)};
    items = {items, make_setup(100, 100, 0, 0, -8192, -8192)};
    items = {items, make_setup(100, 100, 10, 10, 0, 50)};
    items = {items, make_setup(100, 100, 10, 10, 50, 0)};
    items = {items, make_setup(0, 0, 5, 5, 100, 100)};
    items = {items, make_setup(701, 701, 0, 0, 100, 100)};
    items = {items, make_setup(801, 100, 0, 0, 100, 100)};
    items = {items, make_setup(100, 8191, 0, 0, 100, 10)};
    items = {items, make_setup(600, 300, 1800, 900, 500, 500)};
    items = {items, make_setup(1, 1, 1919, 1079, 1, 1)};
    items = {items, make_setup(200, 300, 0, 0, 200, 150)};
    items = {items, make_setup(2, 2, 0, 0, 3, 3)};
    feed_setups(items);

    // directed cases at the largest display
    set_display(8191, 8191);
    items = {};
    items = {items, make_setup(8191, 8191, 0, 0, 8191, 8191)};
    items = {items, make_setup(8191, 8191, -8192, -8192, 8191, 8191)};
    items = {items, make_setup(1, 1, 8190, 8190, 1, 1)};
    items = {items, make_setup(8191, 1, 0, 0, 1024, 8191)};
    feed_setups(items);

    // random phases over several display sizes
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin dw = 8191; dh = 8191; count = 150; end
        1: begin dw = 1; dh = 1; count = 30; end
        2: begin dw = 8191; dh = 1; count = 30; end
        3: begin dw = 1; dh = 8191; count = 30; end
        4: begin dw = 0; dh = 1080; count = 10; end
        5: begin dw = 1920; dh = 1080; count = 150; end
        default: begin
          dw = $urandom_range(2, 8191);
          dh = $urandom_range(2, 8191);
          count = 120;
        end
      endcase
      set_display(dw, dh);
      items = {};
      repeat (count) items = {items, random_setup(dw, dh)};
      feed_setups(items);
    end

    // let the last results drain
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
